// ----- src/bsi_pkg.sv -----
// Package for the broadcast source index unit.
// Holds the sizes, register codes, pipeline word types and the dimension size helpers.
// No dependencies.
`default_nettype none
package bsi_pkg;

  localparam int MaxDims = 4;
  localparam int DimBits = 16;
  localparam int IdxW    = 32;
  localparam int ShapeW  = 64;
  localparam int MaskW   = 4;
  localparam int NumOps  = 3;
  localparam int CntW    = 3;
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DIM_COUNT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUT_SHAPE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_MASK  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_MASK    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_MASK = 3'd4;

  // Word travelling along the divider cells.
  typedef struct packed {
    logic                            valid;
    logic [IdxW-1:0]                 w;
    logic [DimBits-1:0]              r;
    logic [MaxDims-1:0][DimBits-1:0] coord;
  } div_t;

  // Word travelling along the accumulator cells.
  typedef struct packed {
    logic                            valid;
    logic [IdxW-1:0]                 w;
    logic [MaxDims-1:0][DimBits-1:0] coord;
    logic [NumOps-1:0][IdxW-1:0]     idx;
    logic [NumOps-1:0][IdxW-1:0]     stride;
  } acc_t;

  // Dimensions in use: zero reads as one, large values clip to the maximum.
  function automatic logic [CntW:0] used_dims(input logic [CntW-1:0] dc);
    logic [CntW:0] n;
    n = {1'b0, dc};
    if (n == '0) n = (CntW+1)'(1);
    if (n > (CntW+1)'(MaxDims)) n = (CntW+1)'(MaxDims);
    return n;
  endfunction

  // Size of dimension k; zero or a lane past the register reads as one.
  function automatic logic [DimBits-1:0] dim_size(input logic [ShapeW-1:0] shape,
                                                   input int k);
    logic [ShapeW-1:0]  sh;
    logic [DimBits-1:0] lane;
    sh   = '0;
    lane = DimBits'(1);
    if (k * DimBits < ShapeW) begin
      sh   = shape >> (k * DimBits);
      lane = sh[DimBits-1:0];
      if (lane == '0) lane = DimBits'(1);
    end
    return lane;
  endfunction

endpackage
`default_nettype wire

// ----- src/bsi_div_cell.sv -----
// One restoring division step: brings in one dividend bit and yields one quotient bit.
// Depends on bsi_pkg.
`default_nettype none
module bsi_div_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bsi_pkg::div_t               in_i,
  input  wire logic [bsi_pkg::DimBits-1:0] divisor_i,
  output bsi_pkg::div_t                    out_o
);

  bsi_pkg::div_t               d;
  logic [bsi_pkg::DimBits:0]   t;
  logic                        ge;
  logic                        valid_q;
  bsi_pkg::div_t               data_q;

  // Shift the top dividend bit into the remainder and subtract where it fits.
  always_comb begin
    d  = in_i;
    t  = {in_i.r, in_i.w[bsi_pkg::IdxW-1]};
    ge = (t >= {1'b0, divisor_i});
    d.r = ge ? bsi_pkg::DimBits'(t - {1'b0, divisor_i}) : t[bsi_pkg::DimBits-1:0];
    d.w = {in_i.w[bsi_pkg::IdxW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= d;
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule
`default_nettype wire

// ----- src/bsi_acc_cell.sv -----
// One dimension of the source index build for all three operands.
// Depends on bsi_pkg.
`default_nettype none
module bsi_acc_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bsi_pkg::acc_t               in_i,
  input  wire logic [bsi_pkg::IdxW-1:0]    coord_i,
  input  wire logic [bsi_pkg::DimBits-1:0] size_i,
  input  wire logic [bsi_pkg::NumOps-1:0]  skip_i,
  output bsi_pkg::acc_t                    out_o
);

  bsi_pkg::acc_t d;
  logic          valid_q;
  bsi_pkg::acc_t data_q;

  // A dimension that is not broadcast adds coordinate times stride and grows the stride.
  always_comb begin
    d = in_i;
    for (int o = 0; o < bsi_pkg::NumOps; o++) begin
      if (!skip_i[o]) begin
        d.idx[o]    = in_i.idx[o] + bsi_pkg::IdxW'(coord_i * in_i.stride[o]);
        d.stride[o] = bsi_pkg::IdxW'(in_i.stride[o] * {{(bsi_pkg::IdxW-bsi_pkg::DimBits){1'b0}},
                                                       size_i});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= d;
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule
`default_nettype wire

// ----- src/broadcast_source_index_unit.sv -----
// Top level of the broadcast source index unit: configuration registers and the cell chains.
// Depends on bsi_pkg, bsi_div_cell and bsi_acc_cell.
//
// One word is taken in every cycle and busy_o stays low. The output index is split into
// coordinates innermost first by a chain of one-bit division cells, 32 per inner dimension,
// then one accumulator cell per dimension builds the three source indices. A word leaves the
// last accumulator cell marked by a one-cycle done_o pulse; the receiver cannot stall it.
// The user must write configuration only while no word is in the chains; the block itself
// does not enforce it.
`default_nettype none
module broadcast_source_index_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bsi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bsi_pkg::ShapeW-1:0]  cfg_data_i,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [bsi_pkg::IdxW-1:0]    out_index_i,
  output logic                             done_o,
  output logic [bsi_pkg::IdxW-1:0]         start_index_o,
  output logic [bsi_pkg::IdxW-1:0]         end_index_o,
  output logic [bsi_pkg::IdxW-1:0]         weight_index_o
);

  localparam int NDiv = (bsi_pkg::MaxDims - 1) * bsi_pkg::IdxW;

  logic [bsi_pkg::CntW-1:0]   dim_count_q;
  logic [bsi_pkg::ShapeW-1:0] shape_q;
  logic [bsi_pkg::MaskW-1:0]  start_mask_q;
  logic [bsi_pkg::MaskW-1:0]  end_mask_q;
  logic [bsi_pkg::MaskW-1:0]  weight_mask_q;
  logic [bsi_pkg::CntW:0]     n_used;

  bsi_pkg::div_t div_s [NDiv+1];
  bsi_pkg::acc_t acc_s [bsi_pkg::MaxDims+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q   <= bsi_pkg::CntW'(1);
      shape_q       <= 64'h0001_0001_0001_0001;
      start_mask_q  <= '0;
      end_mask_q    <= '0;
      weight_mask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsi_pkg::CFG_DIM_COUNT:   dim_count_q   <= cfg_data_i[bsi_pkg::CntW-1:0];
        bsi_pkg::CFG_OUT_SHAPE:   shape_q       <= cfg_data_i;
        bsi_pkg::CFG_START_MASK:  start_mask_q  <= cfg_data_i[bsi_pkg::MaskW-1:0];
        bsi_pkg::CFG_END_MASK:    end_mask_q    <= cfg_data_i[bsi_pkg::MaskW-1:0];
        bsi_pkg::CFG_WEIGHT_MASK: weight_mask_q <= cfg_data_i[bsi_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  assign n_used = bsi_pkg::used_dims(dim_count_q);
  assign busy_o = 1'b0;

  // Entry word.
  always_comb begin
    div_s[0]       = '0;
    div_s[0].valid = start_i;
    div_s[0].w     = out_index_i;
  end

  // Division chain: each inner dimension divides the running quotient by its size.
  for (genvar i = 0; i < NDiv; i++) begin : g_div
    localparam int K     = bsi_pkg::MaxDims - 1 - i / bsi_pkg::IdxW;
    localparam int Bit   = i % bsi_pkg::IdxW;
    localparam int KNext = (K + 1 < bsi_pkg::MaxDims) ? K + 1 : K;
    bsi_pkg::div_t           cin;
    logic [bsi_pkg::DimBits-1:0] dsz;

    always_comb begin
      cin = div_s[i];
      if (Bit == 0) begin
        cin.r = '0;
        if (i > 0) cin.coord[KNext] = div_s[i].r;
      end
      dsz = (K < int'(n_used)) ? bsi_pkg::dim_size(shape_q, K) : bsi_pkg::DimBits'(1);
    end

    bsi_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_i      (cin),
      .divisor_i (dsz),
      .out_o     (div_s[i+1])
    );
  end

  // Hand over from the divider to the accumulators.
  always_comb begin
    acc_s[0]       = '0;
    acc_s[0].valid = div_s[NDiv].valid;
    acc_s[0].w     = div_s[NDiv].w;
    acc_s[0].coord = div_s[NDiv].coord;
    if (NDiv > 0) acc_s[0].coord[1] = div_s[NDiv].r;
    for (int o = 0; o < bsi_pkg::NumOps; o++) begin
      acc_s[0].stride[o] = bsi_pkg::IdxW'(1);
    end
  end

  // Accumulator chain, innermost dimension first.
  for (genvar j = 0; j < bsi_pkg::MaxDims; j++) begin : g_acc
    localparam int K = bsi_pkg::MaxDims - 1 - j;
    logic [bsi_pkg::IdxW-1:0]    c;
    logic [bsi_pkg::NumOps-1:0]  skip;
    logic [bsi_pkg::NumOps-1:0]  mbit;

    always_comb begin
      if (K == 0) begin
        c = acc_s[j].w;
      end else begin
        c = {{(bsi_pkg::IdxW-bsi_pkg::DimBits){1'b0}}, acc_s[j].coord[K]};
      end
      mbit = '0;
      if (K < bsi_pkg::MaskW) begin
        mbit[0] = start_mask_q[K];
        mbit[1] = end_mask_q[K];
        mbit[2] = weight_mask_q[K];
      end
      skip = mbit | {bsi_pkg::NumOps{!(K < int'(n_used))}};
    end

    bsi_acc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .in_i    (acc_s[j]),
      .coord_i (c),
      .size_i  (bsi_pkg::dim_size(shape_q, K)),
      .skip_i  (skip),
      .out_o   (acc_s[j+1])
    );
  end

  // Result word.
  assign done_o         = acc_s[bsi_pkg::MaxDims].valid;
  assign start_index_o  = acc_s[bsi_pkg::MaxDims].idx[0];
  assign end_index_o    = acc_s[bsi_pkg::MaxDims].idx[1];
  assign weight_index_o = acc_s[bsi_pkg::MaxDims].idx[2];

endmodule
`default_nettype wire
